// ===== src/piu_pkg.sv =====
// ----------------------------------------------------------------------------
// piu_pkg
// Shared types, constants and microcode table for the packed index unpacker.
// ----------------------------------------------------------------------------
`default_nettype none

package piu_pkg;

    localparam int WORD_BITS  = 64;
    localparam int BPOS_W     = 7;
    localparam int CFG_W      = 5;
    localparam int INDEX_W    = 16;
    localparam int POS_OUT_W  = 12;
    localparam int OUT_DATA_W = 32;
    localparam int STEP_W     = 2;

    localparam logic [CFG_W-1:0] CFG_RESET = 5'd4;

    // micro-ops
    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_MERGE   = 2'd1;
    localparam logic [1:0] OP_EXTRACT = 2'd2;
    localparam logic [1:0] OP_NOP     = 2'd3;

    // jump conditions
    localparam logic [1:0] COND_ALWAYS = 2'd0;
    localparam logic [1:0] COND_SPILL  = 2'd1;
    localparam logic [1:0] COND_FIT    = 2'd2;
    localparam logic [1:0] COND_NEVER  = 2'd3;

    // program steps
    localparam logic [STEP_W-1:0] STEP_FETCH  = 2'd0;
    localparam logic [STEP_W-1:0] STEP_MERGE  = 2'd1;
    localparam logic [STEP_W-1:0] STEP_UNPACK = 2'd2;
    localparam logic [STEP_W-1:0] STEP_SPARE  = 2'd3;

    typedef struct packed {
        logic [1:0]        op;
        logic [1:0]        cond;
        logic [STEP_W-1:0] jump_target;
        logic [STEP_W-1:0] fall_target;
    } ucode_t;

    typedef struct packed {
        logic in_valid;
        logic out_free;
        logic spill_ok;
        logic fit;
    } seq_stat_t;

    typedef struct packed {
        logic in_ready;
        logic load;
        logic merge;
        logic extract;
        logic save;
    } seq_ctrl_t;

    function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
        ucode_t w;
        unique case (step)
            STEP_FETCH:  w = '{OP_LOAD,    COND_SPILL,  STEP_MERGE,  STEP_UNPACK};
            STEP_MERGE:  w = '{OP_MERGE,   COND_ALWAYS, STEP_UNPACK, STEP_UNPACK};
            STEP_UNPACK: w = '{OP_EXTRACT, COND_FIT,    STEP_UNPACK, STEP_FETCH};
            default:     w = '{OP_NOP,     COND_NEVER,  STEP_FETCH,  STEP_FETCH};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== src/packed_index_unpacker_top.sv =====
// ----------------------------------------------------------------------------
// packed_index_unpacker_top
// Unpacks LSB-first fixed-width indices from a stream of 64-bit words.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one 64-bit packed word per transfer. m_axis carries one
//   unpacked entry per transfer: palette index, position in the section,
//   and tlast on the last entry of a section. cfg writes the entry width
//   (1..MAX_WIDTH, 0 acts as 1); a write restarts spill and position.
//   Write cfg only while idle.
// Steps:
//   A word runs one fetch step, one step per entry it completes in the
//   sequencer's unpack loop (about 64/width, 16 at width 4) and one step
//   to save the leftover bits. A merged straddling entry costs its own
//   step. Each step that emits an entry writes it into the output
//   register; a full output register holds the emitting step.
// Reset:
//   Width 4, no spill bits, position 0, output empty.
// Stall:
//   The output register holds its entry until taken; the sequencer waits
//   on the emitting step, no entry is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module packed_index_unpacker_top #(
    parameter int SECTION_ENTRIES = 4096,
    parameter int MAX_WIDTH       = 16
) (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             cfg_valid,
    output logic                            cfg_ready,
    input  wire  [piu_pkg::CFG_W-1:0]       cfg_data,
    input  wire                             s_axis_tvalid,
    output logic                            s_axis_tready,
    input  wire  [piu_pkg::WORD_BITS-1:0]   s_axis_tdata,   // [63:0] packed_word
    output logic                            m_axis_tvalid,
    input  wire                             m_axis_tready,
    output logic [piu_pkg::OUT_DATA_W-1:0]  m_axis_tdata,   // [15:0] palette_index,
                                                            // [27:16] entry_position
    output logic                            m_axis_tlast    // section_last
);
    import piu_pkg::*;

    localparam int WW     = $clog2(MAX_WIDTH + 1);
    localparam int POS_W  = $clog2(SECTION_ENTRIES);
    localparam int BSUM_W = BPOS_W + 1;
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(SECTION_ENTRIES - 1);

    seq_stat_t stat;
    seq_ctrl_t ctrl;

    logic [CFG_W-1:0]      width_reg,       width_next;
    logic [MAX_WIDTH-1:0]  spill_bits_reg,  spill_bits_next;
    logic [WW-1:0]         spill_count_reg, spill_count_next;
    logic [POS_W-1:0]      pos_cnt_reg,     pos_cnt_next;
    logic [WORD_BITS-1:0]  word_reg,        word_next;
    logic [BPOS_W-1:0]     bpos_reg,        bpos_next;
    logic                  m_valid_reg,     m_valid_next;
    logic [INDEX_W-1:0]    m_index_reg,     m_index_next;
    logic [POS_OUT_W-1:0]  m_pos_reg,       m_pos_next;
    logic                  m_last_reg,      m_last_next;

    logic [WW-1:0]         eff_width;
    logic [MAX_WIDTH-1:0]  mask;
    logic [WORD_BITS-1:0]  shifted;
    logic [MAX_WIDTH-1:0]  merge_val;
    logic [MAX_WIDTH-1:0]  ext_val;
    logic [MAX_WIDTH-1:0]  emit_val;
    logic                  emit;

    piu_sequencer u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    always_comb
    begin
        if (width_reg == '0)
        begin
            eff_width = WW'(1);
        end
        else if (int'(width_reg) > MAX_WIDTH)
        begin
            eff_width = WW'(MAX_WIDTH);
        end
        else
        begin
            eff_width = WW'(width_reg);
        end

        mask      = ~({MAX_WIDTH{1'b1}} << eff_width);
        shifted   = word_reg >> bpos_reg;
        merge_val = (spill_bits_reg | (word_reg[MAX_WIDTH-1:0] << spill_count_reg)) & mask;
        ext_val   = shifted[MAX_WIDTH-1:0] & mask;

        stat.in_valid = s_axis_tvalid;
        stat.out_free = !m_valid_reg || m_axis_tready;
        stat.spill_ok = (spill_count_reg != '0) && (spill_count_reg < eff_width);
        stat.fit      = (BSUM_W'(bpos_reg) + BSUM_W'(eff_width)) <= BSUM_W'(WORD_BITS);

        width_next       = width_reg;
        spill_bits_next  = spill_bits_reg;
        spill_count_next = spill_count_reg;
        pos_cnt_next     = pos_cnt_reg;
        word_next        = word_reg;
        bpos_next        = bpos_reg;
        m_index_next     = m_index_reg;
        m_pos_next       = m_pos_reg;
        m_last_next      = m_last_reg;
        m_valid_next     = m_valid_reg && !m_axis_tready;

        if (ctrl.load)
        begin
            word_next = s_axis_tdata;
            bpos_next = '0;
        end

        if (ctrl.merge)
        begin
            bpos_next = BPOS_W'(eff_width - spill_count_reg);
        end

        if (ctrl.extract)
        begin
            bpos_next = bpos_reg + BPOS_W'(eff_width);
        end

        if (ctrl.save)
        begin
            spill_count_next = WW'(BPOS_W'(WORD_BITS) - bpos_reg);
            spill_bits_next  = shifted[MAX_WIDTH-1:0];
        end

        emit     = ctrl.merge || ctrl.extract;
        emit_val = ctrl.merge ? merge_val : ext_val;
        if (emit)
        begin
            m_valid_next = 1'b1;
            m_index_next = INDEX_W'(emit_val);
            m_pos_next   = POS_OUT_W'(pos_cnt_reg);
            m_last_next  = (pos_cnt_reg == POS_LAST);
            pos_cnt_next = (pos_cnt_reg >= POS_LAST) ? '0 : pos_cnt_reg + 1'b1;
        end

        if (cfg_valid)
        begin
            width_next       = cfg_data;
            spill_bits_next  = '0;
            spill_count_next = '0;
            pos_cnt_next     = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg       <= CFG_RESET;
            spill_bits_reg  <= '0;
            spill_count_reg <= '0;
            pos_cnt_reg     <= '0;
            m_valid_reg     <= 1'b0;
        end
        else
        begin
            width_reg       <= width_next;
            spill_bits_reg  <= spill_bits_next;
            spill_count_reg <= spill_count_next;
            pos_cnt_reg     <= pos_cnt_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg    <= word_next;
        bpos_reg    <= bpos_next;
        m_index_reg <= m_index_next;
        m_pos_reg   <= m_pos_next;
        m_last_reg  <= m_last_next;
    end

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = ctrl.in_ready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {(OUT_DATA_W - INDEX_W - POS_OUT_W)'(0), m_pos_reg, m_index_reg};
    assign m_axis_tlast  = m_last_reg;

endmodule

`default_nettype wire

// ===== src/piu_sequencer.sv =====
// ----------------------------------------------------------------------------
// piu_sequencer
// Step counter and microcode table; issues one control word per step.
// ----------------------------------------------------------------------------
`default_nettype none

module piu_sequencer (
    input  wire                 clk,
    input  wire                 rst_n,
    input  piu_pkg::seq_stat_t  stat,
    output piu_pkg::seq_ctrl_t  ctrl
);
    import piu_pkg::*;

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    ucode_t            uw;
    logic              cond_hit;
    logic              stall;

    always_comb
    begin
        uw = ucode_rom(step_reg);

        unique case (uw.cond)
            COND_ALWAYS: cond_hit = 1'b1;
            COND_SPILL:  cond_hit = stat.spill_ok;
            COND_FIT:    cond_hit = stat.fit;
            default:     cond_hit = 1'b0;
        endcase

        ctrl = '0;
        unique case (uw.op)
            OP_LOAD:
            begin
                ctrl.in_ready = 1'b1;
                ctrl.load     = stat.in_valid;
                stall         = !stat.in_valid;
            end
            OP_MERGE:
            begin
                ctrl.merge = stat.out_free;
                stall      = !stat.out_free;
            end
            OP_EXTRACT:
            begin
                ctrl.extract = cond_hit && stat.out_free;
                ctrl.save    = !cond_hit;
                stall        = cond_hit && !stat.out_free;
            end
            default:
            begin
                stall = 1'b0;
            end
        endcase

        step_next = step_reg;
        if (!stall)
        begin
            step_next = cond_hit ? uw.jump_target : uw.fall_target;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_FETCH;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/piu_checker.sv =====
// ----------------------------------------------------------------------------
// piu_checker
// Port-level assertions for packed_index_unpacker_top, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module piu_checker #(
    parameter int SECTION_ENTRIES = 4096,
    parameter int MAX_WIDTH       = 16
) (
    input wire                             clk,
    input wire                             rst_n,
    input wire                             cfg_valid,
    input wire                             cfg_ready,
    input wire [piu_pkg::CFG_W-1:0]        cfg_data,
    input wire                             s_axis_tvalid,
    input wire                             s_axis_tready,
    input wire                             m_axis_tvalid,
    input wire                             m_axis_tready,
    input wire [piu_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    input wire                             m_axis_tlast
);
    import piu_pkg::*;

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam logic [POS_OUT_W-1:0] POS_LAST_OUT = POS_OUT_W'(SECTION_ENTRIES - 1);

    logic [CFG_W-1:0] width_reg;
    logic [WW-1:0]    eff_width;
    logic             s_fire;

    assign s_fire = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        if (width_reg == '0)
        begin
            eff_width = WW'(1);
        end
        else if (int'(width_reg) > MAX_WIDTH)
        begin
            eff_width = WW'(MAX_WIDTH);
        end
        else
        begin
            eff_width = WW'(width_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= CFG_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            width_reg <= cfg_data;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output changed while stalled");

    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[27:16] == POS_LAST_OUT)
        else $error("tlast away from the section's last position");

    a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
        s_fire |=> !s_axis_tready)
        else $error("second word taken before the first was unpacked");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[15:0] >> eff_width) == 16'd0)
        else $error("index wider than the entry width");

endmodule

bind packed_index_unpacker_top piu_checker #(
    .SECTION_ENTRIES (SECTION_ENTRIES),
    .MAX_WIDTH       (MAX_WIDTH)
) u_piu_checker (.*);

`default_nettype wire

// ===== bench/packed_index_unpacker_top_tb.sv =====
// ----------------------------------------------------------------------------
// packed_index_unpacker_top_tb
// Self-checking bench for the packed index unpacker.
// ----------------------------------------------------------------------------
// Packed words go in on s_axis from a queue. Each accepted word runs through
// a behavioral unpacker that keeps its own spill bits and section position.
// That model queues the entries the word should produce. Every m_axis
// transfer is checked against the oldest queued entry. The bench first sends
// a few directed words at several widths: straddling entries, max width,
// out-of-range width values and width 1 with a section wrap. Random phases
// follow with varied widths and varied source and sink throttling. Every
// width write happens only while the block is drained.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module packed_index_unpacker_top_tb;

    import piu_pkg::*;

    localparam int SECTION_ENTRIES = 4096;
    localparam int MAX_WIDTH       = 16;
    localparam int IDLE_LIMIT      = 5000;

    typedef struct {
        logic [INDEX_W-1:0]   palette_index;
        logic [POS_OUT_W-1:0] entry_position;
        logic                 section_last;
    } entry_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_W-1:0]      cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [WORD_BITS-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;

    logic [WORD_BITS-1:0]  pending_words[$];
    entry_t                expected_entries[$];

    // unpacker state mirror
    logic [CFG_W-1:0]      width_reg = CFG_RESET;
    logic [15:0]           spill_bits = '0;
    int                    spill_cnt = 0;
    logic [POS_OUT_W-1:0]  pos_ctr = '0;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int fail_count     = 0;
    int idle_cycles    = 0;

    packed_index_unpacker_top #(
        .SECTION_ENTRIES(SECTION_ENTRIES),
        .MAX_WIDTH      (MAX_WIDTH)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic [WORD_BITS-1:0] low_mask(input int n);
        return (64'd1 << n) - 64'd1;
    endfunction

    function automatic void queue_word(input logic [WORD_BITS-1:0] word);
        pending_words.insert(pending_words.size(), word);
    endfunction

    function automatic void push_entry(input logic [WORD_BITS-1:0] value);
        entry_t e;
        e.palette_index  = value[INDEX_W-1:0];
        e.entry_position = pos_ctr;
        e.section_last   = (pos_ctr == POS_OUT_W'(SECTION_ENTRIES - 1));
        expected_entries.insert(expected_entries.size(), e);
        if (pos_ctr == POS_OUT_W'(SECTION_ENTRIES - 1))
            pos_ctr = '0;
        else
            pos_ctr = pos_ctr + 1'b1;
    endfunction

    function automatic void predict_entries(input logic [WORD_BITS-1:0] word);
        int w;
        int bitpos;
        int need;
        w = int'(width_reg);
        if (w < 1)
            w = 1;
        if (w > MAX_WIDTH)
            w = MAX_WIDTH;
        if (spill_cnt >= w)
        begin
            spill_cnt  = 0;
            spill_bits = '0;
        end
        bitpos = 0;
        if (spill_cnt > 0)
        begin
            need = w - spill_cnt;
            push_entry((64'(spill_bits) & low_mask(spill_cnt)) |
                       ((word & low_mask(need)) << spill_cnt));
            bitpos = need;
        end
        while (bitpos + w <= WORD_BITS)
        begin
            push_entry((word >> bitpos) & low_mask(w));
            bitpos += w;
        end
        if (bitpos < WORD_BITS)
        begin
            spill_cnt  = WORD_BITS - bitpos;
            spill_bits = 16'((word >> bitpos) & low_mask(spill_cnt));
        end
        else
        begin
            spill_cnt  = 0;
            spill_bits = '0;
        end
    endfunction

    function automatic logic [WORD_BITS-1:0] rand_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return 64'd1 << $urandom_range(0, 63);
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    // source: one word per transfer from pending_words
    always @(posedge clk)
    begin
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                predict_entries(s_axis_tdata);
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_words.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= pending_words.pop_front();
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // sink: check each entry transfer against the oldest expected entry
    always @(posedge clk)
    begin
        entry_t e;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_entries.size() == 0)
                begin
                    $error("unexpected entry: palette_index %0h entry_position %0d",
                           m_axis_tdata[INDEX_W-1:0], m_axis_tdata[INDEX_W +: POS_OUT_W]);
                    fail_count++;
                end
                else
                begin
                    e = expected_entries.pop_front();
                    if (m_axis_tdata[INDEX_W-1:0] !== e.palette_index)
                    begin
                        $error("palette_index: expected %0h, got %0h",
                               e.palette_index, m_axis_tdata[INDEX_W-1:0]);
                        fail_count++;
                    end
                    if (m_axis_tdata[INDEX_W +: POS_OUT_W] !== e.entry_position)
                    begin
                        $error("entry_position: expected %0d, got %0d",
                               e.entry_position, m_axis_tdata[INDEX_W +: POS_OUT_W]);
                        fail_count++;
                    end
                    if (m_axis_tlast !== e.section_last)
                    begin
                        $error("section_last: expected %0b, got %0b",
                               e.section_last, m_axis_tlast);
                        fail_count++;
                    end
                end
            end
            m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    task automatic set_throttle(input int mode);
        case (mode)
            0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1:       begin send_idle_pct = 62; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 62; end
            default: begin send_idle_pct = 8;  recv_stall_pct = 8;  end
        endcase
    endtask

    task automatic drain(input int tail);
        do
            @(negedge clk);
        while (pending_words.size() != 0 || s_axis_tvalid || expected_entries.size() != 0);
        repeat (tail) @(negedge clk);
    endtask

    task automatic write_width(input logic [CFG_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid  <= 1'b0;
        width_reg  = value;
        spill_bits = '0;
        spill_cnt  = 0;
        pos_ctr    = '0;
    endtask

    task automatic push_random(input int n);
        repeat (n) queue_word(rand_word());
    endtask

    initial
    begin
        logic [CFG_W-1:0] widths[4];
        widths = '{5'd16, 5'd2, 5'd31, 5'd9};
        set_throttle(0);
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        // reset width of 4: aligned entries
        queue_word(64'h0);
        queue_word(64'hFFFF_FFFF_FFFF_FFFF);
        queue_word(64'hAAAA_AAAA_AAAA_AAAA);
        queue_word(64'h5555_5555_5555_5555);
        queue_word(64'h0123_4567_89AB_CDEF);
        queue_word(64'h8000_0000_0000_0000);
        drain(6);

        // width 5: entries straddle words
        write_width(5'd5);
        queue_word(64'hFEDC_BA98_7654_3210);
        queue_word(64'hFFFF_FFFF_FFFF_FFFF);
        queue_word(64'h0);
        queue_word(64'h8000_0000_0000_0001);
        queue_word(64'h5555_5555_5555_5555);
        drain(6);

        write_width(5'd16);
        queue_word(64'hFFFF_0000_FFFF_0000);
        queue_word(64'h1234_5678_9ABC_DEF0);
        queue_word(64'hFFFF_FFFF_FFFF_FFFF);
        drain(6);

        // above max acts as max
        write_width(5'd31);
        queue_word(64'hDEAD_BEEF_CAFE_F00D);
        queue_word(64'hFFFF_FFFF_FFFF_FFFF);
        queue_word(64'h0001_0002_0003_0004);
        drain(6);

        // zero acts as one
        write_width(5'd0);
        queue_word(64'hA5A5_5A5A_0FF0_F00F);
        queue_word(64'hFFFF_FFFF_FFFF_FFFF);
        queue_word(64'h0);
        drain(6);

        write_width(5'd3);
        queue_word(64'hFFFF_FFFF_FFFF_FFFF);
        queue_word(64'h0);
        queue_word(64'h9249_2492_4924_9249);
        queue_word(64'h8000_0000_0000_0000);
        drain(6);

        // width 1: 64 entries per word, runs past a full section
        write_width(5'd1);
        push_random(70);
        drain(6);

        for (int ph = 0; ph < 10; ph++)
        begin
            write_width(ph < 4 ? widths[ph] : CFG_W'($urandom_range(0, 31)));
            set_throttle(ph % 4);
            if (ph % 2 == 1)
            begin
                push_random(12);
                drain(0);
                push_random(12);
            end
            else
                push_random(24);
            drain(6);
        end

        drain(20);
        if (fail_count == 0 && expected_entries.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
src/piu_pkg.sv
src/piu_sequencer.sv
src/packed_index_unpacker_top.sv
src/piu_checker.sv
bench/packed_index_unpacker_top_tb.sv
